FILE: design/gsfr_pkg.sv
// Package for the GPIO status frame reporter.
// Holds the status codes, frame markers, state and command types.
// No dependencies.
package gsfr_pkg;

    // Per-pin status codes (bit 0 set means driven output)
    localparam logic [2:0] STATUS_OUT_HIGH = 3'h3;
    localparam logic [2:0] STATUS_OUT_LOW  = 3'h1;
    localparam logic [2:0] STATUS_IN_HIGH  = 3'h6;
    localparam logic [2:0] STATUS_IN_LOW   = 3'h4;
    localparam logic [2:0] STATUS_RESET    = 3'h0;

    // Request opcodes
    localparam logic OP_DRIVE = 1'b0;
    localparam logic OP_SCAN  = 1'b1;

    // Frame markers
    localparam logic [7:0] BYTE_START = 8'h53;
    localparam logic [7:0] BYTE_END   = 8'h45;

    // Field widths
    localparam int PIN_W   = 5;
    localparam int LEVEL_W = 30;
    localparam int CNT_W   = 6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_START,
        ST_COUNT,
        ST_PINS,
        ST_END
    } state_t;

    typedef enum logic [1:0] {
        SEL_START,
        SEL_COUNT,
        SEL_PIN,
        SEL_END
    } sel_t;

    typedef struct packed {
        logic drive_we;
        logic scan_we;
        logic sum;
        logic load_work;
        logic load_count;
        logic pop;
        sel_t sel;
    } cmd_t;

    typedef struct packed {
        logic work_any;
        logic work_one;
    } stat_t;

endpackage

FILE: design/gsfr_dp.sv
// Datapath of the GPIO status frame reporter: status table, active count,
// pending-pin mask and frame byte select. Uses gsfr_pkg.
module gsfr_dp #(
    parameter int PIN_COUNT = 30
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  gsfr_pkg::cmd_t            cmd,
    input  logic [gsfr_pkg::PIN_W-1:0]   pin,
    input  logic                      drive_high,
    input  logic [gsfr_pkg::LEVEL_W-1:0] input_levels,
    output gsfr_pkg::stat_t           stat,
    output logic [7:0]                frame_byte
);

    localparam int NGRP = (PIN_COUNT + 7) / 8;

    logic [2:0] status_reg [PIN_COUNT];
    logic [2:0] status_next [PIN_COUNT];
    logic [PIN_COUNT-1:0] lv_pin;
    logic [PIN_COUNT-1:0] act;
    logic [NGRP*8-1:0]    act_pad;
    logic [3:0]           grp_reg [NGRP];
    logic [3:0]           grp_next [NGRP];
    logic [gsfr_pkg::CNT_W-1:0] count_reg;
    logic [gsfr_pkg::CNT_W-1:0] count_sum;
    logic [PIN_COUNT-1:0] work_reg;
    logic [PIN_COUNT-1:0] work_next;
    logic [PIN_COUNT-1:0] work_rest;
    logic [gsfr_pkg::PIN_W-1:0] sel_idx;
    logic [2:0]           sel_status;

    // Levels beyond the input field read as low
    assign lv_pin = PIN_COUNT'({{PIN_COUNT{1'b0}}, input_levels});

    // Status table update on drive and scan requests
    always_comb
    begin
        for (int i = 0; i < PIN_COUNT; i++)
        begin
            status_next[i] = status_reg[i];
            if (cmd.drive_we && (gsfr_pkg::PIN_W'(i) == pin))
            begin
                status_next[i] = drive_high ? gsfr_pkg::STATUS_OUT_HIGH
                                            : gsfr_pkg::STATUS_OUT_LOW;
            end
            if (cmd.scan_we && !status_reg[i][0])
            begin
                status_next[i] = lv_pin[i] ? gsfr_pkg::STATUS_IN_HIGH
                                           : gsfr_pkg::STATUS_IN_LOW;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIN_COUNT; i++)
            begin
                status_reg[i] <= gsfr_pkg::STATUS_RESET;
            end
        end
        else
        begin
            for (int i = 0; i < PIN_COUNT; i++)
            begin
                status_reg[i] <= status_next[i];
            end
        end
    end

    // Mark active pins (driven high or input high)
    always_comb
    begin
        for (int i = 0; i < PIN_COUNT; i++)
        begin
            act[i] = (status_reg[i] == gsfr_pkg::STATUS_OUT_HIGH) ||
                     (status_reg[i] == gsfr_pkg::STATUS_IN_HIGH);
        end
    end

    assign act_pad = (NGRP*8)'(act);

    // Count active pins in groups of eight
    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_next[g] = '0;
            for (int b = 0; b < 8; b++)
            begin
                grp_next[g] = grp_next[g] + 4'(act_pad[g*8+b]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sum)
        begin
            for (int g = 0; g < NGRP; g++)
            begin
                grp_reg[g] <= grp_next[g];
            end
        end
    end

    // Add the group counts
    always_comb
    begin
        count_sum = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            count_sum = count_sum + gsfr_pkg::CNT_W'(grp_reg[g]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_count)
        begin
            count_reg <= count_sum;
        end
    end

    // Pending-pin mask: load on scan, drop lowest pin as each pin byte leaves
    assign work_rest = work_reg & (work_reg - PIN_COUNT'(1));

    always_comb
    begin
        work_next = work_reg;
        if (cmd.load_work)
        begin
            work_next = act;
        end
        else if (cmd.pop)
        begin
            work_next = work_rest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_reg <= '0;
        end
        else
        begin
            work_reg <= work_next;
        end
    end

    assign stat.work_any = |work_reg;
    assign stat.work_one = (work_rest == '0);

    // Find the lowest pending pin
    always_comb
    begin
        sel_idx    = '0;
        sel_status = gsfr_pkg::STATUS_RESET;
        for (int i = PIN_COUNT - 1; i >= 0; i--)
        begin
            if (work_reg[i])
            begin
                sel_idx    = gsfr_pkg::PIN_W'(i);
                sel_status = status_reg[i];
            end
        end
    end

    // Frame byte select
    always_comb
    begin
        case (cmd.sel)
            gsfr_pkg::SEL_START: frame_byte = gsfr_pkg::BYTE_START;
            gsfr_pkg::SEL_COUNT: frame_byte = 8'(count_reg);
            gsfr_pkg::SEL_PIN:   frame_byte = {sel_idx, sel_status};
            gsfr_pkg::SEL_END:   frame_byte = gsfr_pkg::BYTE_END;
            default:             frame_byte = gsfr_pkg::BYTE_END;
        endcase
    end

endmodule

FILE: design/gsfr_ctrl.sv
// Controller of the GPIO status frame reporter: request handshake and
// frame sequencing. Uses gsfr_pkg.
module gsfr_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            op,
    input  logic            out_ready,
    input  gsfr_pkg::stat_t stat,
    output logic            in_ready,
    output logic            out_valid,
    output logic            last,
    output gsfr_pkg::cmd_t  cmd
);

    gsfr_pkg::state_t state_reg;
    gsfr_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gsfr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gsfr_pkg::ST_IDLE:
            begin
                if (in_valid && (op == gsfr_pkg::OP_SCAN))
                begin
                    state_next = gsfr_pkg::ST_SUM;
                end
            end
            gsfr_pkg::ST_SUM:
            begin
                state_next = gsfr_pkg::ST_START;
            end
            gsfr_pkg::ST_START:
            begin
                if (out_ready)
                begin
                    state_next = gsfr_pkg::ST_COUNT;
                end
            end
            gsfr_pkg::ST_COUNT:
            begin
                if (out_ready)
                begin
                    state_next = stat.work_any ? gsfr_pkg::ST_PINS : gsfr_pkg::ST_END;
                end
            end
            gsfr_pkg::ST_PINS:
            begin
                if (out_ready && stat.work_one)
                begin
                    state_next = gsfr_pkg::ST_END;
                end
            end
            gsfr_pkg::ST_END:
            begin
                if (out_ready)
                begin
                    state_next = gsfr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gsfr_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath commands
    always_comb
    begin
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        last          = 1'b0;
        cmd.drive_we  = 1'b0;
        cmd.scan_we   = 1'b0;
        cmd.sum       = 1'b0;
        cmd.load_work = 1'b0;
        cmd.load_count = 1'b0;
        cmd.pop       = 1'b0;
        cmd.sel       = gsfr_pkg::SEL_START;
        case (state_reg)
            gsfr_pkg::ST_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.drive_we = in_valid && (op == gsfr_pkg::OP_DRIVE);
                cmd.scan_we  = in_valid && (op == gsfr_pkg::OP_SCAN);
            end
            gsfr_pkg::ST_SUM:
            begin
                cmd.sum       = 1'b1;
                cmd.load_work = 1'b1;
            end
            gsfr_pkg::ST_START:
            begin
                out_valid      = 1'b1;
                cmd.load_count = 1'b1;
                cmd.sel        = gsfr_pkg::SEL_START;
            end
            gsfr_pkg::ST_COUNT:
            begin
                out_valid = 1'b1;
                cmd.sel   = gsfr_pkg::SEL_COUNT;
            end
            gsfr_pkg::ST_PINS:
            begin
                out_valid = 1'b1;
                cmd.sel   = gsfr_pkg::SEL_PIN;
                cmd.pop   = out_ready;
            end
            gsfr_pkg::ST_END:
            begin
                out_valid = 1'b1;
                last      = 1'b1;
                cmd.sel   = gsfr_pkg::SEL_END;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

FILE: design/gpio_status_frame_reporter.sv
// Top level of the GPIO status frame reporter.
// Joins gsfr_ctrl and gsfr_dp; uses gsfr_pkg.
//
//   channel   direction  handshake             payload
//   in        input      in_valid / in_ready   op, pin, drive_high, input_levels
//   out       output     out_valid / out_ready frame_byte, last
//
// A drive request yields no bytes. A scan request first updates the status
// table, then registers the grouped active count, then sends the frame
// bytes: 3 + active pins bytes. With out_ready high, one byte per cycle
// is the limit of the lowest-pending-pin search. Reset clears the status
// table to undriven inputs. A stall on out_ready holds the current byte;
// no request is taken while a frame is in progress.
module gpio_status_frame_reporter #(
    parameter int PIN_COUNT = 30
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [4:0]  pin,
    input  logic        drive_high,
    input  logic [29:0] input_levels,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  frame_byte,
    output logic        last
);

    gsfr_pkg::cmd_t  cmd;
    gsfr_pkg::stat_t stat;

    gsfr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .op        (op),
        .out_ready (out_ready),
        .stat      (stat),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .last      (last),
        .cmd       (cmd)
    );

    gsfr_dp #(
        .PIN_COUNT (PIN_COUNT)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .pin          (pin),
        .drive_high   (drive_high),
        .input_levels (input_levels),
        .stat         (stat),
        .frame_byte   (frame_byte)
    );

    // Never take a request while a frame byte is on offer
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("request taken during frame");

    // Closing byte frees the input side
    a_end_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last) |=> in_ready)
        else $error("no return to idle after frame end");

    // Scan request leads to a start byte after the count cycle
    a_scan_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && op) |=> !out_valid ##1
        (out_valid && !last && frame_byte == gsfr_pkg::BYTE_START))
        else $error("scan did not open a frame");

    // Drive request yields no output
    a_drive_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !op) |=> (in_ready && !out_valid))
        else $error("drive produced output");

endmodule
